[rtl/core/tcc_pkg.sv]
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the text console cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

package tcc_pkg;

  localparam int OPCODE_W = 2;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 16;
  localparam int CFG_IDX_W = 2;

  localparam int TAB_WIDTH_DEFAULT = 8;

  localparam logic [BYTE_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [BYTE_W-1:0] ROWS_RESET    = 8'd25;
  localparam logic [BYTE_W-1:0] ATTR_RESET    = 8'd0;

  localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

  typedef enum logic [OPCODE_W-1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_SET_POS    = 2'd1,
    OP_SET_CHAR   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS = 2'd0,
    CFG_ROWS    = 2'd1,
    CFG_ATTR    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_CHAR,
    CMD_CR,
    CMD_LF,
    CMD_TAB,
    CMD_SET_POS,
    CMD_SET_CHAR,
    CMD_BAD
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [BYTE_W-1:0] char_code;
    logic [BYTE_W-1:0] col;
    logic [BYTE_W-1:0] row;
    logic              in_range;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] columns;
    logic [BYTE_W-1:0] rows;
    logic [BYTE_W-1:0] attr;
  } cfg_t;

  typedef enum logic {
    BK_CMD,
    BK_TAB
  } bk_state_t;

endpackage

`default_nettype wire

[rtl/core/tcc_cmd_if.sv]
// ----------------------------------------------------------------------------
// tcc_cmd_if
// Command channel: opcode, character and target position.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_cmd_if;
  import tcc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] target_col;
  logic [BYTE_W-1:0] target_row;

  modport source (output valid, output opcode, output char_code,
                  output target_col, output target_row, input ready);
  modport sink   (input valid, input opcode, input char_code,
                  input target_col, input target_row, output ready);
endinterface

`default_nettype wire

[rtl/core/tcc_res_if.sv]
// ----------------------------------------------------------------------------
// tcc_res_if
// Result channel: one cell write or status word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_res_if;
  import tcc_pkg::*;

  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [INDEX_W-1:0] cell_index;
  logic [BYTE_W-1:0]  char_byte;
  logic [BYTE_W-1:0]  attr_byte;
  logic               ok;
  logic               last;

  modport source (output valid, output write_enable, output cell_index,
                  output char_byte, output attr_byte, output ok, output last,
                  input ready);
  modport sink   (input valid, input write_enable, input cell_index,
                  input char_byte, input attr_byte, input ok, input last,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/tcc_cfg_if.sv]
// ----------------------------------------------------------------------------
// tcc_cfg_if
// Configuration write channel: register index and data.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcc_cfg_if;
  import tcc_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [BYTE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/tcc_front.sv]
// ----------------------------------------------------------------------------
// tcc_front
// Command classifier: decodes opcode and control characters and does the
// bounds checks for set position and direct cell write.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_front (
  tcc_cmd_if.sink         cmd,
  input  tcc_pkg::cfg_t   cfg,
  input  logic            q_ready,
  output logic            push,
  output tcc_pkg::cmd_t   push_cmd
);
  import tcc_pkg::*;

  assign cmd.ready = q_ready;
  assign push      = cmd.valid && q_ready;

  always_comb begin
    push_cmd.char_code = cmd.char_code;
    push_cmd.col       = cmd.target_col;
    push_cmd.row       = cmd.target_row;
    push_cmd.in_range  = 1'b0;
    push_cmd.kind      = CMD_BAD;
    unique case (cmd.opcode)
      OP_WRITE_CHAR: begin
        push_cmd.in_range = 1'b1;
        if (cmd.char_code == CHAR_CR) begin
          push_cmd.kind = CMD_CR;
        end else if (cmd.char_code == CHAR_LF) begin
          push_cmd.kind = CMD_LF;
        end else if (cmd.char_code == CHAR_TAB) begin
          push_cmd.kind = CMD_TAB;
        end else begin
          push_cmd.kind = CMD_CHAR;
        end
      end
      OP_SET_POS: begin
        // column equal to the width is legal: it defers the wrap
        push_cmd.kind     = CMD_SET_POS;
        push_cmd.in_range = !(cmd.target_col > cfg.columns ||
                              cmd.target_row >= cfg.rows);
      end
      OP_SET_CHAR: begin
        push_cmd.kind     = CMD_SET_CHAR;
        push_cmd.in_range = !(cmd.target_col >= cfg.columns ||
                              cmd.target_row >= cfg.rows);
      end
      default: begin
        push_cmd.kind = CMD_BAD;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/tcc_queue.sv]
// ----------------------------------------------------------------------------
// tcc_queue
// Two-entry command queue between the classifier and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcc_pkg::cmd_t push_cmd,
  output logic          q_ready,
  input  logic          pop,
  output logic          q_valid,
  output tcc_pkg::cmd_t head
);
  import tcc_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // no words taken while in reset
  assign q_ready = !rst && (count != 2'd2);
  assign q_valid = (count != 2'd0);
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/tcc_back.sv]
// ----------------------------------------------------------------------------
// tcc_back
// Command executor: owns the cursor, steps through tab fills one cell per
// cycle while the result port is not stalled and registers each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_back #(
  parameter int TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  tcc_pkg::cfg_t cfg,
  input  logic          q_valid,
  input  tcc_pkg::cmd_t head,
  output logic          pop,
  tcc_res_if.source     res
);
  import tcc_pkg::*;

  localparam int NUM_COLS = 1 << BYTE_W;
  localparam logic [BYTE_W:0] TAB_W9 = (BYTE_W+1)'(TAB_WIDTH);

  bk_state_t state;
  bk_state_t state_next;

  logic [BYTE_W-1:0] col;
  logic [BYTE_W-1:0] row;
  logic [BYTE_W-1:0] col_next;
  logic [BYTE_W-1:0] row_next;

  logic               out_valid;
  logic               out_we;
  logic [INDEX_W-1:0] out_index;
  logic [BYTE_W-1:0]  out_char;
  logic [BYTE_W-1:0]  out_attr;
  logic               out_ok;
  logic               out_last;

  // tab stop table, one bit per column
  logic [NUM_COLS-1:0] stop_tab;

  for (genvar i = 0; i < NUM_COLS; i++) begin : g_stop
    assign stop_tab[i] = ((i % TAB_WIDTH) == 0);
  end

  function automatic logic [BYTE_W-1:0] row_inc(input logic [BYTE_W-1:0] r,
                                                input logic [BYTE_W-1:0] rows);
    logic [BYTE_W:0] r1;
    r1 = {1'b0, r} + 9'd1;
    return (r1 >= {1'b0, rows}) ? '0 : r1[BYTE_W-1:0];
  endfunction

  logic              fire;
  logic              wrap;
  logic [BYTE_W-1:0] c0;
  logic [BYTE_W-1:0] r0;
  logic [BYTE_W:0]   c1;
  logic [BYTE_W:0]   room0;
  logic [BYTE_W:0]   room1;
  logic [BYTE_W-1:0] r0_inc;
  logic              tab_more;

  logic              we;
  logic [BYTE_W-1:0] wr_char;
  logic              ok;
  logic              last;
  logic [BYTE_W-1:0] mc;
  logic [BYTE_W-1:0] mr;
  logic [INDEX_W-1:0] prod;
  logic [INDEX_W-1:0] idx;

  assign fire = q_valid && (!out_valid || res.ready);
  assign pop  = fire && last;

  // deferred wrap applies only on entry to a printable character or tab command
  assign wrap  = (col >= cfg.columns);
  assign c0    = (state == BK_TAB) ? col : (wrap ? '0 : col);
  assign r0    = (state == BK_TAB) ? row : (wrap ? row_inc(row, cfg.rows) : row);
  assign c1    = {1'b0, c0} + 9'd1;
  assign room0 = {1'b0, cfg.columns} - {1'b0, c0};
  assign room1 = {1'b0, cfg.columns} - c1;
  assign r0_inc = row_inc(r0, cfg.rows);

  assign mc   = (head.kind == CMD_SET_CHAR) ? head.col : c0;
  assign mr   = (head.kind == CMD_SET_CHAR) ? head.row : r0;
  assign prod = INDEX_W'(mr) * INDEX_W'(cfg.columns);
  assign idx  = prod + INDEX_W'(mc);

  // result word and cursor update
  always_comb begin
    we       = 1'b0;
    wr_char  = '0;
    ok       = 1'b1;
    last     = 1'b1;
    tab_more = 1'b0;
    col_next = col;
    row_next = row;
    unique case (head.kind)
      CMD_CR: begin
        col_next = '0;
      end
      CMD_LF: begin
        col_next = '0;
        row_next = row_inc(row, cfg.rows);
      end
      CMD_CHAR: begin
        we       = 1'b1;
        wr_char  = head.char_code;
        col_next = c1[BYTE_W-1:0];
        row_next = r0;
      end
      CMD_TAB: begin
        if (stop_tab[c0]) begin
          col_next = c0;
          row_next = r0;
        end else if (room0 < TAB_W9) begin
          col_next = '0;
          row_next = r0_inc;
        end else begin
          we      = 1'b1;
          wr_char = CHAR_SPACE;
          if (stop_tab[c1[BYTE_W-1:0]]) begin
            col_next = c1[BYTE_W-1:0];
            row_next = r0;
          end else if (room1 < TAB_W9) begin
            col_next = '0;
            row_next = r0_inc;
          end else begin
            last     = 1'b0;
            tab_more = 1'b1;
            col_next = c1[BYTE_W-1:0];
            row_next = r0;
          end
        end
      end
      CMD_SET_POS: begin
        ok = head.in_range;
        if (head.in_range) begin
          col_next = head.col;
          row_next = head.row;
        end
      end
      CMD_SET_CHAR: begin
        ok      = head.in_range;
        we      = head.in_range;
        wr_char = head.char_code;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    if (fire) begin
      state_next = tab_more ? BK_TAB : BK_CMD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BK_CMD;
      col       <= '0;
      row       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        col       <= col_next;
        row       <= row_next;
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_we    <= we;
      out_index <= we ? idx : '0;
      out_char  <= we ? wr_char : '0;
      out_attr  <= we ? cfg.attr : '0;
      out_ok    <= ok;
      out_last  <= last;
    end
  end

  assign res.valid        = out_valid;
  assign res.write_enable = out_we;
  assign res.cell_index   = out_index;
  assign res.char_byte    = out_char;
  assign res.attr_byte    = out_attr;
  assign res.ok           = out_ok;
  assign res.last         = out_last;

endmodule

`default_nettype wire

[rtl/core/text_console_cursor_writer.sv]
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// Text-mode console engine: cursor tracking and character-cell writes.
// ----------------------------------------------------------------------------
// A command word is decoded in the cycle it is accepted and lands in a
// two-entry queue; the executor behind it owns the cursor and emits one
// result word per cycle unless the result port stalls, through a queue
// slot and then an output register. Every command gives one result word,
// except a tab, which gives one word per space written (a single word if it
// writes none), up to TAB_WIDTH-1 words. The rate is set by the executor,
// each word through one 8x8 cell-index multiply and add. Results carry
// last on the final word of each command. Configuration writes are
// accepted whenever reset is low and take effect on the next cycle.
`default_nettype none

module text_console_cursor_writer #(
  parameter int TAB_WIDTH = tcc_pkg::TAB_WIDTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  tcc_cmd_if.sink   cmd,
  tcc_res_if.source res,
  tcc_cfg_if.sink   cfg
);
  import tcc_pkg::*;

  cfg_t cfg_regs;
  logic q_ready;
  logic q_valid;
  logic push;
  logic pop;
  cmd_t push_cmd;
  cmd_t head;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.columns <= COLUMNS_RESET;
      cfg_regs.rows    <= ROWS_RESET;
      cfg_regs.attr    <= ATTR_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_COLUMNS: cfg_regs.columns <= cfg.data;
        CFG_ROWS:    cfg_regs.rows    <= cfg.data;
        CFG_ATTR:    cfg_regs.attr    <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  tcc_front u_front (
    .cmd      (cmd),
    .cfg      (cfg_regs),
    .q_ready  (q_ready),
    .push     (push),
    .push_cmd (push_cmd)
  );

  tcc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  tcc_back #(
    .TAB_WIDTH (TAB_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .res     (res)
  );

endmodule

`default_nettype wire

[rtl/core/tcc_checker.sv]
// ----------------------------------------------------------------------------
// tcc_checker
// Port-level checks for the text console cursor writer.
// ----------------------------------------------------------------------------
`default_nettype none

module tcc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        write_enable,
  input logic [15:0] cell_index,
  input logic [7:0]  char_byte,
  input logic [7:0]  attr_byte,
  input logic        ok,
  input logic        last
);

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_index) && $stable(last))
    else $error("result word changed while stalled");

  // a word without a write carries zero payload
  a_nowrite_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !write_enable |-> cell_index == 16'd0 && char_byte == 8'd0 &&
                                   attr_byte == 8'd0)
    else $error("non-write word has payload");

  a_fail_nowrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !ok |-> !write_enable && last)
    else $error("failed command wrote a cell");

  // only tab fills span several words, and those are spaces
  a_multi_space: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> write_enable && ok && char_byte == 8'h20)
    else $error("unexpected multi-word result");

endmodule

bind text_console_cursor_writer tcc_checker u_tcc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (res.valid),
  .out_ready    (res.ready),
  .write_enable (res.write_enable),
  .cell_index   (res.cell_index),
  .char_byte    (res.char_byte),
  .attr_byte    (res.attr_byte),
  .ok           (res.ok),
  .last         (res.last)
);

`default_nettype wire
